// ===== hw/rtl/aes_key_slot_scrambler_macros.svh =====
// Assertion macros shared by the key-slot scrambler RTL.
`ifndef AES_KEY_SLOT_SCRAMBLER_MACROS_SVH
`define AES_KEY_SLOT_SCRAMBLER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define AKS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define AKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/aks_pkg.sv =====
// Types, codes and constants of the key-slot scrambler.
package aks_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_KEY_SLOT   = 2'd0;
    localparam logic [1:0] CFG_WORD_ORDER = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN = 2'd2;

    // Input function codes
    localparam logic [1:0] FUNC_NORMAL = 2'd0;
    localparam logic [1:0] FUNC_X      = 2'd1;
    localparam logic [1:0] FUNC_Y      = 2'd2;
    localparam logic [1:0] FUNC_DIRECT = 2'd3;

    // Key part codes of a direct write
    localparam logic [1:0] PART_NORMAL = 2'd0;
    localparam logic [1:0] PART_X      = 2'd1;
    localparam logic [1:0] PART_Y      = 2'd2;

    // Scrambler constants and rotations
    localparam logic [127:0] C_ONE = 128'h1FF9E9AAC5FE0408_024591DC5D52768A;
    localparam logic [127:0] C_TWO = 128'hFFFEFB4E29590258_2A680F5F1A4F3E79;
    localparam int ROL_X_FILL   = 2;
    localparam int ROR_FILL     = 41;
    localparam int ROL_DIRECT   = 42;
    localparam int KEY_W        = 128;
    localparam int BUF_WORDS    = 4;
    localparam int CFG_DATA_W   = 6;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  key_part;
        logic [1:0]  direct_slot;
        logic [1:0]  word_index;
        logic [31:0] data_word;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  slot;
        logic [63:0] key_half;
        logic        is_high_half;
        logic        last;
    } t_result;

    // Store operation of one accepted word
    typedef enum logic [2:0] {
        OP_NFILL = 3'd0,
        OP_XFILL = 3'd1,
        OP_YFILL = 3'd2,
        OP_DNORM = 3'd3,
        OP_DX    = 3'd4,
        OP_DY    = 3'd5
    } t_op;

    // Assembly buffer control
    typedef struct packed {
        logic       accept;
        logic [1:0] func;
        logic       word_order;
        logic       clear;
    } t_buf_ctl;

    // Shared adder control
    typedef struct packed {
        logic load;
        logic sel_c2;
    } t_add_ctl;

    // Key store write enables
    typedef struct packed {
        logic we_n;
        logic we_x;
        logic we_y;
    } t_ks_wr;

    function automatic logic [31:0] swap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    // Replace the word at register index idx (position 3 - idx)
    function automatic logic [127:0] ins_word(input logic [127:0] row,
                                              input logic [1:0] idx,
                                              input logic [31:0] w);
        logic [127:0] r;
        r = row;
        r[{idx, 5'b00000} +: 32] = w;
        return r;
    endfunction

endpackage

// ===== hw/rtl/aks_buffers.sv =====
// Normal, X and Y word assembly buffers with their fill counters.
module aks_buffers
    import aks_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_buf_ctl       i_ctl,
    input  logic [31:0]    i_word,
    output logic           o_done,
    output logic [127:0]   o_nkey,
    output logic [127:0]   o_xkey,
    output logic [127:0]   o_ykey
);

    logic [1:0]  r_cnt [3];
    logic [31:0] r_buf [3][BUF_WORDS];
    logic [1:0]  w_cur;

    // Pick the counter of the addressed buffer
    always_comb begin
        case (i_ctl.func)
            FUNC_NORMAL: w_cur = r_cnt[0];
            FUNC_X:      w_cur = r_cnt[1];
            FUNC_Y:      w_cur = r_cnt[2];
            default:     w_cur = 2'd0;
        endcase
    end

    // Flag the word that fills its buffer
    assign o_done = (i_ctl.func != FUNC_DIRECT) && (w_cur == 2'd3);

    // Place words and advance counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_cnt[k] <= 2'd0;
                for (int j = 0; j < BUF_WORDS; j++) begin
                    r_buf[k][j] <= '0;
                end
            end
        end else if (i_ctl.clear) begin
            for (int k = 0; k < 3; k++) begin
                r_cnt[k] <= 2'd0;
            end
        end else if (i_ctl.accept) begin
            for (int k = 0; k < 3; k++) begin
                if (i_ctl.func == 2'(k)) begin
                    r_buf[k][i_ctl.word_order ? r_cnt[k] : ~r_cnt[k]] <= i_word;
                    r_cnt[k] <= r_cnt[k] + 2'd1;
                end
            end
        end
    end

    // Word position 0 is the most significant
    assign o_nkey = {r_buf[0][0], r_buf[0][1], r_buf[0][2], r_buf[0][3]};
    assign o_xkey = {r_buf[1][0], r_buf[1][1], r_buf[1][2], r_buf[1][3]};
    assign o_ykey = {r_buf[2][0], r_buf[2][1], r_buf[2][2], r_buf[2][3]};

endmodule

// ===== hw/rtl/aks_keystore.sv =====
// Normal, X and Y key memories, one 128-bit row per slot, with row valid bits.
module aks_keystore
    import aks_pkg::*;
#(
    parameter int SLOT_COUNT = 64,
    parameter int SLOT_W     = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [SLOT_W-1:0] i_addr,
    input  t_ks_wr            i_wr,
    input  logic [127:0]      i_wr_norm,
    input  logic [127:0]      i_wr_row,
    output logic [127:0]      o_norm,
    output logic [127:0]      o_x,
    output logic [127:0]      o_y
);

    logic [127:0]          r_mem_n [SLOT_COUNT];
    logic [127:0]          r_mem_x [SLOT_COUNT];
    logic [127:0]          r_mem_y [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_vld_n;
    logic [SLOT_COUNT-1:0] r_vld_x;
    logic [SLOT_COUNT-1:0] r_vld_y;
    logic [127:0]          r_rd_n;
    logic [127:0]          r_rd_x;
    logic [127:0]          r_rd_y;
    logic                  r_rv_n;
    logic                  r_rv_x;
    logic                  r_rv_y;

    // Write rows and read them back registered
    always_ff @(posedge i_clk) begin
        if (i_wr.we_n) begin
            r_mem_n[i_addr] <= i_wr_norm;
        end
        if (i_wr.we_x) begin
            r_mem_x[i_addr] <= i_wr_row;
        end
        if (i_wr.we_y) begin
            r_mem_y[i_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_n <= r_mem_n[i_addr];
            r_rd_x <= r_mem_x[i_addr];
            r_rd_y <= r_mem_y[i_addr];
        end
    end

    // Mark written rows; reset leaves every row reading as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_n <= '0;
            r_vld_x <= '0;
            r_vld_y <= '0;
            r_rv_n  <= 1'b0;
            r_rv_x  <= 1'b0;
            r_rv_y  <= 1'b0;
        end else begin
            if (i_wr.we_n) begin
                r_vld_n[i_addr] <= 1'b1;
            end
            if (i_wr.we_x) begin
                r_vld_x[i_addr] <= 1'b1;
            end
            if (i_wr.we_y) begin
                r_vld_y[i_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rv_n <= r_vld_n[i_addr];
                r_rv_x <= r_vld_x[i_addr];
                r_rv_y <= r_vld_y[i_addr];
            end
        end
    end

    assign o_norm = r_rv_n ? r_rd_n : '0;
    assign o_x    = r_rv_x ? r_rd_x : '0;
    assign o_y    = r_rv_y ? r_rd_y : '0;

endmodule

// ===== hw/rtl/aks_adder.sv =====
// Shared 128-bit adder that adds one scrambler constant 32 bits per cycle.
module aks_adder
    import aks_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_add_ctl     i_ctl,
    input  logic [127:0] i_opnd,
    output logic [127:0] o_sum,
    output logic         o_done
);

    logic [127:0] r_acc;
    logic         r_carry;
    logic [1:0]   r_cnt;
    logic         r_busy;
    logic         r_sel;
    logic [127:0] w_c;
    logic [31:0]  w_cword;
    logic [32:0]  w_step;

    // One 32-bit slice per cycle, low slice first
    assign w_c     = r_sel ? C_TWO : C_ONE;
    assign w_cword = w_c[{r_cnt, 5'b00000} +: 32];
    assign w_step  = {1'b0, r_acc[31:0]} + {1'b0, w_cword} + {32'd0, r_carry};

    // Sequence the four slices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
        end else if (i_ctl.load) begin
            r_busy <= 1'b1;
            r_cnt  <= 2'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 2'd1;
            if (r_cnt == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Rotate sums in from the top while the operand shifts down
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_acc   <= i_opnd;
            r_carry <= 1'b0;
            r_sel   <= i_ctl.sel_c2;
        end else if (r_busy) begin
            r_acc   <= {w_step[31:0], r_acc[127:32]};
            r_carry <= w_step[32];
        end
    end

    assign o_sum  = r_acc;
    assign o_done = r_busy && (r_cnt == 2'd3);

endmodule

// ===== hw/rtl/aes_key_slot_scrambler.sv =====
// Key-slot store with key scrambler: top level sequencer and register file.
// Each beat on i_item is one 32-bit key register write, taken when i_start is high
// and o_busy is low. A word that does not complete a key update is absorbed in the
// accept cycle and the block stays free. A completed X buffer or a direct X write
// keeps the block busy through the key memory read, the merge and the write. A
// completed normal buffer or a direct normal write keeps it busy through the read,
// merge and write, then the two result beats. A completed Y buffer or a direct Y
// write keeps it busy through the read and merge, then the 128-bit constant add on
// one shared 32-bit adder, the rotate, the write and the two result beats. Results
// come as a pair on o_result, each valid for exactly one cycle under o_result_valid,
// high half first; the receiver cannot stall them. The key memories need no clearing
// pass after reset: a valid bit per slot makes an unwritten row read as zero.
`include "aes_key_slot_scrambler_macros.svh"

module aes_key_slot_scrambler
    import aks_pkg::*;
#(
    parameter int SLOT_COUNT = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_in_item              i_item,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_result_valid,
    output t_result               o_result
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam logic [6:0] SLOT_LIMIT = 7'(SLOT_COUNT);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_READ   = 8'b0000_0010,
        S_LOAD   = 8'b0000_0100,
        S_ADD    = 8'b0000_1000,
        S_ROT    = 8'b0001_0000,
        S_WRITE  = 8'b0010_0000,
        S_OUT_HI = 8'b0100_0000,
        S_OUT_LO = 8'b1000_0000
    } t_state;

    t_state       r_state, n_state;
    logic [5:0]   r_key_slot;
    logic         r_word_order;
    logic         r_big_endian;
    t_op          r_op, n_op;
    logic [5:0]   r_slot;
    logic [1:0]   r_widx;
    logic [31:0]  r_word;
    logic [127:0] r_key;
    logic [127:0] r_row;

    logic         w_accept;
    logic         w_act;
    logic         w_slot_ok;
    logic [31:0]  w_word;
    logic         w_buf_done;
    logic [127:0] w_nbuf, w_xbuf, w_ybuf;
    logic [127:0] w_rd_n, w_rd_x, w_rd_y;
    logic [127:0] w_ynew;
    logic [127:0] w_sum;
    logic         w_add_done;
    logic [127:0] w_opnd;
    t_buf_ctl     w_buf_ctl;
    t_add_ctl     w_add_ctl;
    t_ks_wr       w_ks_wr;

    assign o_busy    = (r_state != S_IDLE);
    assign w_accept  = i_start && !o_busy;
    assign w_slot_ok = ({1'b0, r_key_slot} < SLOT_LIMIT);
    assign w_word    = r_big_endian ? swap32(i_item.data_word) : i_item.data_word;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_slot   <= 6'd0;
            r_word_order <= 1'b0;
            r_big_endian <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_SLOT:   r_key_slot   <= i_cfg_wdata[5:0];
                CFG_WORD_ORDER: r_word_order <= i_cfg_wdata[0];
                CFG_BIG_ENDIAN: r_big_endian <= i_cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    // Assembly buffers
    always_comb begin
        w_buf_ctl.accept     = w_accept;
        w_buf_ctl.func       = i_item.func;
        w_buf_ctl.word_order = r_word_order;
        w_buf_ctl.clear      = i_cfg_we && (i_cfg_idx == CFG_WORD_ORDER)
                               && (i_cfg_wdata[0] != r_word_order);
    end

    aks_buffers u_buffers (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_buf_ctl),
        .i_word  (w_word),
        .o_done  (w_buf_done),
        .o_nkey  (w_nbuf),
        .o_xkey  (w_xbuf),
        .o_ykey  (w_ybuf)
    );

    // Decode the store operation of an accepted beat
    always_comb begin
        w_act = 1'b0;
        n_op  = OP_NFILL;
        unique case (i_item.func)
            FUNC_NORMAL: begin
                w_act = w_buf_done && w_slot_ok;
                n_op  = OP_NFILL;
            end
            FUNC_X: begin
                w_act = w_buf_done && w_slot_ok;
                n_op  = OP_XFILL;
            end
            FUNC_Y: begin
                w_act = w_buf_done && w_slot_ok;
                n_op  = OP_YFILL;
            end
            FUNC_DIRECT: begin
                unique case (i_item.key_part)
                    PART_NORMAL: begin
                        w_act = 1'b1;
                        n_op  = OP_DNORM;
                    end
                    PART_X: begin
                        w_act = 1'b1;
                        n_op  = OP_DX;
                    end
                    PART_Y: begin
                        w_act = 1'b1;
                        n_op  = OP_DY;
                    end
                    default: w_act = 1'b0;
                endcase
            end
            default: w_act = 1'b0;
        endcase
    end

    // Latch the beat that starts a store update
    always_ff @(posedge i_clk) begin
        if (w_accept && w_act) begin
            r_op   <= n_op;
            r_slot <= (i_item.func == FUNC_DIRECT) ? {4'd0, i_item.direct_slot} : r_key_slot;
            r_widx <= i_item.word_index;
            r_word <= w_word;
        end
    end

    // Key memories
    always_comb begin
        w_ks_wr.we_n = (r_state == S_WRITE) && (r_op != OP_XFILL) && (r_op != OP_DX);
        w_ks_wr.we_x = (r_state == S_WRITE) && ((r_op == OP_XFILL) || (r_op == OP_DX));
        w_ks_wr.we_y = (r_state == S_WRITE) && ((r_op == OP_YFILL) || (r_op == OP_DY));
    end

    aks_keystore #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_keystore (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (r_state == S_READ),
        .i_addr    (r_slot[SLOT_W-1:0]),
        .i_wr      (w_ks_wr),
        .i_wr_norm (r_key),
        .i_wr_row  (r_row),
        .o_norm    (w_rd_n),
        .o_x       (w_rd_x),
        .o_y       (w_rd_y)
    );

    // Build the adder operand from the X and Y keys
    assign w_ynew = ins_word(w_rd_y, r_widx, r_word);
    always_comb begin
        if (r_op == OP_YFILL) begin
            w_opnd = ((w_rd_x << ROL_X_FILL) | (w_rd_x >> (KEY_W - ROL_X_FILL))) ^ w_ybuf;
        end else begin
            w_opnd = w_rd_x ^ w_ynew;
        end
        w_add_ctl.load   = (r_state == S_LOAD) && ((r_op == OP_YFILL) || (r_op == OP_DY));
        w_add_ctl.sel_c2 = (r_op == OP_DY);
    end

    aks_adder u_adder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_add_ctl),
        .i_opnd  (w_opnd),
        .o_sum   (w_sum),
        .o_done  (w_add_done)
    );

    // Form the new key rows
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            case (r_op)
                OP_NFILL: r_key <= w_nbuf;
                OP_XFILL: r_row <= w_xbuf;
                OP_YFILL: r_row <= w_ybuf;
                OP_DNORM: r_key <= ins_word(w_rd_n, r_widx, r_word);
                OP_DX:    r_row <= ins_word(w_rd_x, r_widx, r_word);
                OP_DY:    r_row <= w_ynew;
                default:  ;
            endcase
        end else if (r_state == S_ROT) begin
            if (r_op == OP_YFILL) begin
                r_key <= (w_sum >> ROR_FILL) | (w_sum << (KEY_W - ROR_FILL));
            end else begin
                r_key <= (w_sum << ROL_DIRECT) | (w_sum >> (KEY_W - ROL_DIRECT));
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_act) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_LOAD;
            S_LOAD: begin
                if ((r_op == OP_YFILL) || (r_op == OP_DY)) begin
                    n_state = S_ADD;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_ADD: begin
                if (w_add_done) begin
                    n_state = S_ROT;
                end
            end
            S_ROT: n_state = S_WRITE;
            S_WRITE: begin
                if ((r_op == OP_XFILL) || (r_op == OP_DX)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_OUT_HI;
                end
            end
            S_OUT_HI: n_state = S_OUT_LO;
            S_OUT_LO: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive the result beats
    assign o_result_valid        = (r_state == S_OUT_HI) || (r_state == S_OUT_LO);
    assign o_result.slot         = r_slot;
    assign o_result.key_half     = (r_state == S_OUT_HI) ? r_key[127:64] : r_key[63:0];
    assign o_result.is_high_half = (r_state == S_OUT_HI);
    assign o_result.last         = (r_state == S_OUT_LO);

    // Checks
    `AKS_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n, o_result_valid && o_result.is_high_half, o_result_valid && o_result.last, "high half not followed by low half")
    `AKS_ASSERT_NEXT(a_pair_ends, i_clk, i_rst_n, o_result_valid && o_result.last, !o_result_valid, "extra result after low half")
    `AKS_ASSERT_SAME(a_add_in_state, i_clk, i_rst_n, w_add_done, r_state == S_ADD, "adder finished outside add phase")
    `AKS_ASSERT_SAME(a_busy_on_result, i_clk, i_rst_n, o_result_valid, o_busy && !w_accept, "result beat while block is free")

endmodule
